### sv/dcp_pkg.sv
// shared widths, register codes and word types of the distance constraint core
package dcp_pkg;

   // field widths
   localparam int POS_W     = 32;
   localparam int WT_W      = 24;
   localparam int REST_W    = 31;
   localparam int CSR_IDX_W = 2;

   // datapath widths
   localparam int DIFF_W  = POS_W + 1;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int ROOT_W  = 35;
   localparam int WSUM_W  = WT_W + 1;
   localparam int STEP_W  = ROOT_W;
   localparam int SCALE_W = WT_W + ROOT_W;
   localparam int PROD_W  = STEP_W + DIFF_W;
   localparam int MOVE_W  = 36;
   localparam int ACC_W   = MOVE_W + 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_REST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIAG = 2'd1;

   // register reset values
   localparam logic [REST_W-1:0] REST_RESET = 31'd65536;
   localparam logic [REST_W-1:0] DIAG_RESET = 31'd131072;

   // cycles from the accepting edge to the edge that takes the result
   localparam int LATENCY = 3 + ROOT_W + 1 + STEP_W + 1 + MOVE_W + 1;

   // pair word carried alongside the arithmetic
   typedef struct packed {
      logic                         kind;
      logic [2:0][POS_W-1:0]        p1;
      logic [2:0][POS_W-1:0]        p2;
      logic [2:0]                   neg;
      logic [2:0][DIFF_W-1:0]       ad;
      logic [WT_W-1:0]              w1;
      logic [WT_W-1:0]              w2;
      logic [ROOT_W-1:0]            span;
      logic                         corr;
   } pair_type;

endpackage

### sv/dcp_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage
module dcp_sqrt_pipe #(
   parameter int SQ_W   = 66,
   parameter int ROOT_W = 35,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [SQ_W-1:0]   in_radicand,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);
   localparam int TW = (2 * ROOT_W + 1 > SQ_W) ? 2 * ROOT_W + 1 : SQ_W;

   logic [ROOT_W:1]   valid_ff;
   logic [SQ_W-1:0]   rem_ff  [ROOT_W:1];
   logic [ROOT_W-1:0] root_ff [ROOT_W:1];
   logic [SIDE_W-1:0] side_ff [ROOT_W:1];

   for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
      localparam int B = ROOT_W - 1 - g;
      logic              src_valid;
      logic [SQ_W-1:0]   src_rem;
      logic [ROOT_W-1:0] src_root;
      logic [SIDE_W-1:0] src_side;
      logic [TW-1:0]     trial;
      logic              take;
      logic [SQ_W-1:0]   rem_in;
      logic [ROOT_W-1:0] root_in;

      if (g == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_radicand;
         assign src_root  = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[g];
         assign src_rem   = rem_ff[g];
         assign src_root  = root_ff[g];
         assign src_side  = side_ff[g];
      end

      // try setting root bit B: remainder must cover 2^(B+1)*root + 2^(2B)
      always_comb begin
         trial   = (TW'(src_root) << (B + 1)) + (TW'(1) << (2 * B));
         take    = TW'(src_rem) >= trial;
         rem_in  = take ? SQ_W'(TW'(src_rem) - trial) : src_rem;
         root_in = src_root | (ROOT_W'(take) << B);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g+1] <= 1'b0;
         end else begin
            valid_ff[g+1] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[g+1]  <= rem_in;
         root_ff[g+1] <= root_in;
         side_ff[g+1] <= src_side;
      end
   end

   assign out_valid = valid_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

endmodule

### sv/dcp_div_pipe.sv
// pipelined restoring divider, lanes share one divisor, one quotient bit per stage
module dcp_div_pipe #(
   parameter int LANES  = 2,
   parameter int NUM_W  = 59,
   parameter int DEN_W  = 25,
   parameter int Q_W    = 35,
   parameter int SIDE_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [LANES-1:0][NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0]            in_den,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [LANES-1:0][Q_W-1:0]   out_quot,
   output logic [SIDE_W-1:0]           out_side
);
   logic [Q_W:1]                valid_ff;
   logic [LANES-1:0][NUM_W-1:0] num_ff  [Q_W:1];
   logic [LANES-1:0][Q_W-1:0]   quot_ff [Q_W:1];
   logic [DEN_W-1:0]            den_ff  [Q_W:1];
   logic [SIDE_W-1:0]           side_ff [Q_W:1];

   for (genvar g = 0; g < Q_W; g++) begin : g_stage
      localparam int B = Q_W - 1 - g;
      logic                        src_valid;
      logic [LANES-1:0][NUM_W-1:0] src_num;
      logic [LANES-1:0][Q_W-1:0]   src_quot;
      logic [DEN_W-1:0]            src_den;
      logic [SIDE_W-1:0]           src_side;
      logic [LANES-1:0][NUM_W-1:0] num_in;
      logic [LANES-1:0][Q_W-1:0]   quot_in;
      logic [LANES-1:0]            take;

      if (g == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_num   = in_num;
         assign src_quot  = '0;
         assign src_den   = in_den;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[g];
         assign src_num   = num_ff[g];
         assign src_quot  = quot_ff[g];
         assign src_den   = den_ff[g];
         assign src_side  = side_ff[g];
      end

      // subtract the divisor shifted to bit B where it fits
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            take[l]    = (src_num[l] >> B) >= NUM_W'(src_den);
            num_in[l]  = take[l] ? src_num[l] - (NUM_W'(src_den) << B) : src_num[l];
            quot_in[l] = src_quot[l] | (Q_W'(take[l]) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g+1] <= 1'b0;
         end else begin
            valid_ff[g+1] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         num_ff[g+1]  <= num_in;
         quot_ff[g+1] <= quot_in;
         den_ff[g+1]  <= src_den;
         side_ff[g+1] <= src_side;
      end
   end

   assign out_valid = valid_ff[Q_W];
   assign out_quot  = quot_ff[Q_W];
   assign out_side  = side_ff[Q_W];

endmodule

### sv/distance_constraint_projection_core.sv
// top level of the distance constraint projection pipeline
//
// Usage: pulse start with a particle pair on the req_ ports; the word is taken at
// every rising edge where start is high and busy is low. busy is high only while
// reset is asserted, so a new pair may enter on every clock cycle.
// Each pair yields one result word on the rsp_ ports, marked by rsp_valid for
// exactly one cycle. Throughput is one pair per cycle; the pipeline runs
// through the 35 root-bit stages of the square root, the 35 quotient-bit
// stages of the weight share divider and the 36 quotient-bit stages of the
// per-axis divider by the distance.
// The receiver cannot hold results off; words leave in acceptance order.
// Rest lengths are written through csr_we / csr_index / csr_wdata while the
// pipeline is empty; indexes beyond the diagonal rest are ignored.
// Reset is synchronous: it empties the pipeline and restores both rest lengths
// to their defaults (one unit for edges, two units for diagonals).
module distance_constraint_projection_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_pair_kind,
   input  logic signed [dcp_pkg::POS_W-1:0]    req_first_x,
   input  logic signed [dcp_pkg::POS_W-1:0]    req_first_y,
   input  logic signed [dcp_pkg::POS_W-1:0]    req_first_z,
   input  logic [dcp_pkg::WT_W-1:0]            req_first_weight,
   input  logic signed [dcp_pkg::POS_W-1:0]    req_second_x,
   input  logic signed [dcp_pkg::POS_W-1:0]    req_second_y,
   input  logic signed [dcp_pkg::POS_W-1:0]    req_second_z,
   input  logic [dcp_pkg::WT_W-1:0]            req_second_weight,
   input  logic                                csr_we,
   input  logic [dcp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dcp_pkg::REST_W-1:0]          csr_wdata,
   output logic                                rsp_valid,
   output logic signed [dcp_pkg::POS_W-1:0]    rsp_new_first_x,
   output logic signed [dcp_pkg::POS_W-1:0]    rsp_new_first_y,
   output logic signed [dcp_pkg::POS_W-1:0]    rsp_new_first_z,
   output logic signed [dcp_pkg::POS_W-1:0]    rsp_new_second_x,
   output logic signed [dcp_pkg::POS_W-1:0]    rsp_new_second_y,
   output logic signed [dcp_pkg::POS_W-1:0]    rsp_new_second_z,
   output logic                                rsp_was_corrected
);
   import dcp_pkg::*;

   localparam int PAIR_W = $bits(pair_type);

   // saturate a wide signed value into the position range
   function automatic logic [POS_W-1:0] sat_pos(input logic [ACC_W-1:0] v);
      logic [POS_W-1:0] r;
      if (v[ACC_W-1:POS_W-1] == '0 || v[ACC_W-1:POS_W-1] == '1) begin
         r = v[POS_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(POS_W-1){1'b1}}};
      end
      return r;
   endfunction

   logic                 accept;
   logic [REST_W-1:0]    rest_ff;
   logic [REST_W-1:0]    diag_ff;

   pair_type             pair_in;
   pair_type             s1_pair_ff;
   logic                 s1_valid_ff;
   logic [2:0][SQ_W-1:0] sq_in;
   logic [2:0][SQ_W-1:0] sq_ff;
   pair_type             s2_pair_ff;
   logic                 s2_valid_ff;
   logic [SQ_W-1:0]      sum_ff;
   pair_type             s3_pair_ff;
   logic                 s3_valid_ff;

   logic                 rt_valid;
   logic [ROOT_W-1:0]    rt_root;
   logic [PAIR_W-1:0]    rt_side;
   pair_type             rt_pair;

   pair_type                    e_pair_in;
   logic [1:0][SCALE_W-1:0]     scale_in;
   logic [ROOT_W-1:0]           excess;
   logic [REST_W-1:0]           rest_sel;
   pair_type                    e_pair_ff;
   logic [1:0][SCALE_W-1:0]     scale_ff;
   logic [WSUM_W-1:0]           wsum_ff;
   logic                        e_valid_ff;

   logic                        st_valid;
   logic [1:0][STEP_W-1:0]      st_quot;
   logic [PAIR_W-1:0]           st_side;
   pair_type                    st_pair;

   logic [5:0][PROD_W-1:0]      prod_in;
   logic [5:0][PROD_W-1:0]      prod_ff;
   pair_type                    p_pair_ff;
   logic                        p_valid_ff;

   logic                        mv_valid;
   logic [5:0][MOVE_W-1:0]      mv_quot;
   logic [PAIR_W-1:0]           mv_side;
   pair_type                    mv_pair;

   logic [5:0][POS_W-1:0]       res_in;
   logic [5:0][POS_W-1:0]       res_ff;
   logic                        corr_ff;
   logic                        out_valid_ff;
   logic [ACC_W-1:0]            acc1;
   logic [ACC_W-1:0]            acc2;

   assign busy   = reset;
   assign accept = start & ~busy;

   // rest length registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff <= REST_RESET;
         diag_ff <= DIAG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_REST: rest_ff <= csr_wdata;
            REG_DIAG: diag_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: differences and magnitudes per axis
   always_comb begin
      logic [DIFF_W-1:0] d;
      pair_in      = '0;
      pair_in.kind = req_pair_kind;
      pair_in.p1   = {req_first_z, req_first_y, req_first_x};
      pair_in.p2   = {req_second_z, req_second_y, req_second_x};
      pair_in.w1   = req_first_weight;
      pair_in.w2   = req_second_weight;
      for (int i = 0; i < 3; i++) begin
         d = DIFF_W'(signed'(pair_in.p1[i])) - DIFF_W'(signed'(pair_in.p2[i]));
         pair_in.neg[i] = d[DIFF_W-1];
         pair_in.ad[i]  = d[DIFF_W-1] ? DIFF_W'(-d) : d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage 2: squares
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SQ_W'(s1_pair_ff.ad[i]) * SQ_W'(s1_pair_ff.ad[i]);
      end
   end

   always_ff @(posedge clock) begin
      s1_pair_ff <= pair_in;
      sq_ff      <= sq_in;
      s2_pair_ff <= s1_pair_ff;
      // stage 3: squared distance
      sum_ff     <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      s3_pair_ff <= s2_pair_ff;
   end

   // distance
   dcp_sqrt_pipe #(
      .SQ_W   (SQ_W),
      .ROOT_W (ROOT_W),
      .SIDE_W (PAIR_W)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s3_valid_ff),
      .in_radicand (sum_ff),
      .in_side     (s3_pair_ff),
      .out_valid   (rt_valid),
      .out_root    (rt_root),
      .out_side    (rt_side)
   );

   assign rt_pair = pair_type'(rt_side);

   // excess length, decision and weighted excess
   always_comb begin
      rest_sel       = rt_pair.kind ? diag_ff : rest_ff;
      excess         = rt_root - ROOT_W'(rest_sel);
      e_pair_in      = rt_pair;
      e_pair_in.span = rt_root;
      e_pair_in.corr = (rt_root > ROOT_W'(rest_sel)) &&
                       ((rt_pair.w1 != '0) || (rt_pair.w2 != '0));
      scale_in[0]    = SCALE_W'(rt_pair.w1) * SCALE_W'(excess);
      scale_in[1]    = SCALE_W'(rt_pair.w2) * SCALE_W'(excess);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= rt_valid;
      end
   end

   always_ff @(posedge clock) begin
      e_pair_ff <= e_pair_in;
      scale_ff  <= scale_in;
      wsum_ff   <= WSUM_W'(rt_pair.w1) + WSUM_W'(rt_pair.w2);
   end

   // weight shares of the excess
   dcp_div_pipe #(
      .LANES  (2),
      .NUM_W  (SCALE_W),
      .DEN_W  (WSUM_W),
      .Q_W    (STEP_W),
      .SIDE_W (PAIR_W)
   ) u_share_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_valid_ff),
      .in_num    (scale_ff),
      .in_den    (wsum_ff),
      .in_side   (e_pair_ff),
      .out_valid (st_valid),
      .out_quot  (st_quot),
      .out_side  (st_side)
   );

   assign st_pair = pair_type'(st_side);

   // step times axis magnitude
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i]     = PROD_W'(st_quot[0]) * PROD_W'(st_pair.ad[i]);
         prod_in[3 + i] = PROD_W'(st_quot[1]) * PROD_W'(st_pair.ad[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= st_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      p_pair_ff <= st_pair;
   end

   // per-axis moves, divided by the distance
   dcp_div_pipe #(
      .LANES  (6),
      .NUM_W  (PROD_W),
      .DEN_W  (ROOT_W),
      .Q_W    (MOVE_W),
      .SIDE_W (PAIR_W)
   ) u_move_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid_ff),
      .in_num    (prod_ff),
      .in_den    (p_pair_ff.span),
      .in_side   (p_pair_ff),
      .out_valid (mv_valid),
      .out_quot  (mv_quot),
      .out_side  (mv_side)
   );

   assign mv_pair = pair_type'(mv_side);

   // apply moves with saturation, or pass the pair through
   always_comb begin
      acc1 = '0;
      acc2 = '0;
      for (int i = 0; i < 3; i++) begin
         if (mv_pair.neg[i]) begin
            acc1 = ACC_W'(signed'(mv_pair.p1[i])) + ACC_W'(mv_quot[i]);
            acc2 = ACC_W'(signed'(mv_pair.p2[i])) - ACC_W'(mv_quot[3 + i]);
         end else begin
            acc1 = ACC_W'(signed'(mv_pair.p1[i])) - ACC_W'(mv_quot[i]);
            acc2 = ACC_W'(signed'(mv_pair.p2[i])) + ACC_W'(mv_quot[3 + i]);
         end
         res_in[i]     = mv_pair.corr ? sat_pos(acc1) : mv_pair.p1[i];
         res_in[3 + i] = mv_pair.corr ? sat_pos(acc2) : mv_pair.p2[i];
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= mv_valid;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      corr_ff <= mv_pair.corr;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_new_first_x   = res_ff[0];
   assign rsp_new_first_y   = res_ff[1];
   assign rsp_new_first_z   = res_ff[2];
   assign rsp_new_second_x  = res_ff[3];
   assign rsp_new_second_y  = res_ff[4];
   assign rsp_new_second_z  = res_ff[5];
   assign rsp_was_corrected = out_valid_ff & corr_ff;

`ifndef SYNTH
   // every result word comes from an accepted pair
   a_word_origin : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result word without a matching accepted pair");

   // an uncorrected pair passes the x and z of its first position through unchanged
   a_pass_first : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_was_corrected) |->
         (rsp_new_first_x == $past(req_first_x, LATENCY) &&
          rsp_new_first_z == $past(req_first_z, LATENCY)))
      else $error("uncorrected pair changed its first position");

   // a pair with both weights zero is never corrected
   a_pinned_pair : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_first_weight, LATENCY) == '0 &&
       $past(req_second_weight, LATENCY) == '0) |-> !rsp_was_corrected)
      else $error("pinned pair was moved");
`endif

endmodule

### dv/distance_constraint_projection_core_tb.sv
// testbench for the distance constraint projection core: directed table, random pairs, predictor
`timescale 1ns / 100ps

module distance_constraint_projection_core_tb;
   import dcp_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   // register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 2'd3;

   typedef struct {
      logic                    kind;
      logic signed [POS_W-1:0] first_pos[3];
      logic [WT_W-1:0]         first_wt;
      logic signed [POS_W-1:0] second_pos[3];
      logic [WT_W-1:0]         second_wt;
   } pair_word_type;

   typedef struct {
      logic signed [POS_W-1:0] first_pos[3];
      logic signed [POS_W-1:0] second_pos[3];
      logic                    corrected;
   } moved_word_type;

   typedef struct {
      pair_word_type  pair;
      bit             known;
      moved_word_type moved;
   } table_row_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REST_W-1:0] csr_wdata;
   logic rsp_valid;
   logic signed [POS_W-1:0] rsp_first[3];
   logic signed [POS_W-1:0] rsp_second[3];
   logic rsp_was_corrected;

   pair_word_type  drive_pair;
   bit             drive_known;
   moved_word_type drive_moved;

   logic [REST_W-1:0] edge_len_model;
   logic [REST_W-1:0] diag_len_model;
   moved_word_type moved_queue[$];
   table_row_type  rows[$];
   int fail_count;
   int idle_cycles;
   int pairs_sent;
   int corrected_seen;
   int results_seen;

   distance_constraint_projection_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pair_kind(drive_pair.kind),
      .req_first_x(drive_pair.first_pos[0]), .req_first_y(drive_pair.first_pos[1]),
      .req_first_z(drive_pair.first_pos[2]), .req_first_weight(drive_pair.first_wt),
      .req_second_x(drive_pair.second_pos[0]), .req_second_y(drive_pair.second_pos[1]),
      .req_second_z(drive_pair.second_pos[2]), .req_second_weight(drive_pair.second_wt),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_new_first_x(rsp_first[0]), .rsp_new_first_y(rsp_first[1]),
      .rsp_new_first_z(rsp_first[2]),
      .rsp_new_second_x(rsp_second[0]), .rsp_new_second_y(rsp_second[1]),
      .rsp_new_second_z(rsp_second[2]),
      .rsp_was_corrected(rsp_was_corrected)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // saturate a 41-bit signed sum to the position range
   function automatic logic signed [POS_W-1:0] clamp_pos(logic signed [40:0] v);
      if (v > 41'sd2147483647) return 32'sh7fffffff;
      if (v < -41'sd2147483648) return 32'sh80000000;
      return v[POS_W-1:0];
   endfunction

   // projection of one pair along its joining line
   function automatic moved_word_type project_pair(pair_word_type p,
                                                   logic [REST_W-1:0] edge_len,
                                                   logic [REST_W-1:0] diag_len);
      moved_word_type r;
      logic signed [DIFF_W-1:0] d[3];
      logic [DIFF_W-1:0] ad[3];
      logic [67:0] sq;
      logic [ROOT_W-1:0] root, trial;
      logic [ROOT_W-1:0] rest;
      logic [WSUM_W-1:0] wsum;
      logic [ROOT_W-1:0] excess;
      logic [63:0] share1, share2;
      logic [71:0] m1, m2;
      logic signed [40:0] a1, a2;
      sq = '0;
      root = '0;
      rest = p.kind ? ROOT_W'(diag_len) : ROOT_W'(edge_len);
      wsum = WSUM_W'(p.first_wt) + WSUM_W'(p.second_wt);
      for (int i = 0; i < 3; i++) begin
         d[i] = $signed({p.first_pos[i][POS_W-1], p.first_pos[i]})
              - $signed({p.second_pos[i][POS_W-1], p.second_pos[i]});
         ad[i] = d[i][DIFF_W-1] ? -d[i] : d[i];
         sq = sq + 68'(ad[i]) * 68'(ad[i]);
      end
      // integer square root, one bit per pass
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (ROOT_W'(1) << b);
         if (70'(trial) * 70'(trial) <= 70'(sq)) root = trial;
      end
      r.corrected = (root > rest) && (wsum != 0);
      excess = root - rest;
      share1 = r.corrected ? 64'(p.first_wt) * 64'(excess) / 64'(wsum) : 64'd0;
      share2 = r.corrected ? 64'(p.second_wt) * 64'(excess) / 64'(wsum) : 64'd0;
      for (int i = 0; i < 3; i++) begin
         if (r.corrected) begin
            m1 = 72'(share1) * 72'(ad[i]) / 72'(root);
            m2 = 72'(share2) * 72'(ad[i]) / 72'(root);
            a1 = $signed({1'b0, m1[39:0]});
            a2 = $signed({1'b0, m2[39:0]});
            if (d[i][DIFF_W-1]) begin
               r.first_pos[i]  = clamp_pos(41'(p.first_pos[i]) + a1);
               r.second_pos[i] = clamp_pos(41'(p.second_pos[i]) - a2);
            end else begin
               r.first_pos[i]  = clamp_pos(41'(p.first_pos[i]) - a1);
               r.second_pos[i] = clamp_pos(41'(p.second_pos[i]) + a2);
            end
         end else begin
            r.first_pos[i]  = p.first_pos[i];
            r.second_pos[i] = p.second_pos[i];
         end
      end
      return r;
   endfunction

   // build a pair word
   function automatic pair_word_type make_pair(int kind, int x1, int y1, int z1, int w1,
                                               int x2, int y2, int z2, int w2);
      pair_word_type p;
      p.kind = kind[0];
      p.first_pos[0] = x1; p.first_pos[1] = y1; p.first_pos[2] = z1;
      p.second_pos[0] = x2; p.second_pos[1] = y2; p.second_pos[2] = z2;
      p.first_wt = w1[WT_W-1:0];
      p.second_wt = w2[WT_W-1:0];
      return p;
   endfunction

   // a row whose result is the pair left where it was
   function automatic table_row_type still_row(pair_word_type p);
      table_row_type t;
      t.pair = p;
      t.known = 1'b1;
      t.moved.first_pos = p.first_pos;
      t.moved.second_pos = p.second_pos;
      t.moved.corrected = 1'b0;
      return t;
   endfunction

   function automatic table_row_type checked_row(pair_word_type p);
      table_row_type t;
      t.pair = p;
      t.known = 1'b0;
      t.moved = '{default: '0};
      return t;
   endfunction

   // append a row to the directed table
   function automatic void add_row(table_row_type t);
      rows = {rows, t};
   endfunction

   // append an expected word to the scoreboard
   function automatic void expect_word(moved_word_type m);
      moved_queue = {moved_queue, m};
   endfunction

   // random pair, mostly with separations near the rest lengths
   function automatic pair_word_type random_pair();
      pair_word_type p;
      int shift;
      int mode;
      p.kind = 1'($urandom_range(0, 1));
      shift = $urandom_range(10, 31);
      for (int i = 0; i < 3; i++) begin
         p.second_pos[i] = $urandom;
         if ($urandom_range(0, 7) == 0) p.first_pos[i] = $urandom;
         else p.first_pos[i] = p.second_pos[i] + ($signed($urandom) >>> shift);
      end
      mode = $urandom_range(0, 9);
      p.first_wt  = WT_W'($urandom);
      p.second_wt = WT_W'($urandom);
      if (mode == 0) begin
         p.first_wt = '0;
         p.second_wt = '0;
      end else if (mode == 1) p.first_wt = '0;
      else if (mode == 2) p.second_wt = '0;
      else if (mode == 3) p.first_wt = '1;
      return p;
   endfunction

   // send one word, then idle for a random gap
   task automatic send_pair(pair_word_type p, bit known, moved_word_type m, bit no_gaps);
      int gap;
      int pick;
      @(negedge clock);
      drive_pair = p;
      drive_known = known;
      drive_moved = m;
      start = 1'b1;
      do @(posedge clock); while (busy);
      pairs_sent++;
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 55) gap = 0;
      else if (pick < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // register write while the pipeline is empty
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [REST_W-1:0] val);
      @(negedge clock);
      start = 1'b0;
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      wait (moved_queue.size() == 0);
   endtask

   task automatic random_phase(int count);
      bit no_gaps;
      moved_word_type none;
      none = '{default: '0};
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         send_pair(random_pair(), 1'b0, none, no_gaps);
      end
   endtask

   // monitor: register shadow, expectations, result check, watchdog
   always @(posedge clock) begin
      moved_word_type want;
      if (!reset) begin
         idle_cycles = idle_cycles + 1;
         if (csr_we && csr_index == REG_REST) edge_len_model = csr_wdata;
         if (csr_we && csr_index == REG_DIAG) diag_len_model = csr_wdata;
         if (start && !busy) begin
            idle_cycles = 0;
            if (drive_known) expect_word(drive_moved);
            else expect_word(project_pair(drive_pair, edge_len_model, diag_len_model));
         end
         if (rsp_valid) begin
            idle_cycles = 0;
            results_seen++;
            if (moved_queue.size() == 0) begin
               $error("result word with nothing expected");
               fail_count++;
            end else begin
               want = moved_queue.pop_front();
               for (int i = 0; i < 3; i++) begin
                  if (rsp_first[i] !== want.first_pos[i]) begin
                     $error("new_first axis %0d: expected %0d, got %0d", i,
                            want.first_pos[i], rsp_first[i]);
                     fail_count++;
                  end
                  if (rsp_second[i] !== want.second_pos[i]) begin
                     $error("new_second axis %0d: expected %0d, got %0d", i,
                            want.second_pos[i], rsp_second[i]);
                     fail_count++;
                  end
               end
               if (rsp_was_corrected !== want.corrected) begin
                  $error("was_corrected: expected %0b, got %0b", want.corrected,
                         rsp_was_corrected);
                  fail_count++;
               end
               if (rsp_was_corrected === 1'b1) corrected_seen++;
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", moved_queue.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      table_row_type row;
      int unit;
      unit = 65536;
      reset = 1'b1;
      start = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      drive_pair = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0);
      drive_known = 1'b0;
      drive_moved = '{default: '0};
      edge_len_model = REST_RESET;
      diag_len_model = DIAG_RESET;
      moved_queue = {};
      fail_count = 0;
      idle_cycles = 0;
      pairs_sent = 0;
      corrected_seen = 0;
      results_seen = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table: reset rest lengths of one and two units
      add_row(still_row(make_pair(0, 5, -7, 9, 'hffffff, 5, -7, 9, 'hffffff)));
      add_row(still_row(make_pair(0, unit, 0, 0, 'h10000, 0, 0, 0, 'h10000)));
      add_row(still_row(make_pair(1, 0, 2 * unit, 0, 'h10000, 0, 0, 0, 'h10000)));
      add_row(still_row(make_pair(0, 9 * unit, 0, 0, 0, 0, 0, 0, 0)));
      add_row(still_row(make_pair(1, 1, 1, 1, 'hffffff, 0, 0, 0, 0)));
      add_row(checked_row(make_pair(0, 3 * unit, 0, 0, 'h10000, 0, 0, 0, 'h10000)));
      add_row(checked_row(make_pair(1, 0, 0, -5 * unit, 'h10000, 0, 0, 0, 'h30000)));
      add_row(checked_row(make_pair(0, unit + 1, 0, 0, 'h10000, 0, 0, 0, 'h10000)));
      add_row(checked_row(make_pair(0, 2 * unit, 0, 0, 0, 0, 0, 0, 'hffffff)));
      add_row(checked_row(make_pair(0, 'h7fffffff, 'h7fffffff, 'h7fffffff, 'hffffff,
                                    'h80000000, 'h80000000, 'h80000000, 'hffffff)));
      add_row(checked_row(make_pair(1, 'h80000000, 'h80000000, 'h80000000, 'hffffff,
                                    'h7fffffff, 'h7fffffff, 'h7fffffff, 'hffffff)));
      add_row(checked_row(make_pair(0, 'h7fffffff, 'h80000000, 0, 1,
                                    'h80000000, 'h7fffffff, 0, 'hffffff)));
      add_row(checked_row(make_pair(1, -3 * unit, 4 * unit, 12 * unit, 'h8000,
                                    0, 0, 0, 'h18000)));
      add_row(checked_row(make_pair(0, 'h7fffffff, 0, 0, 1, 'h7ffeffff, 0, 0, 1)));
      add_row(checked_row(make_pair(1, -1, -1, -1, 'haaaaaa, 'h7fffffff, 0, 'h12345,
                                    'h555555)));
      for (int r = 0; r < rows.size(); r++) begin
         row = rows[r];
         send_pair(row.pair, row.known, row.moved, 1'b0);
      end
      random_phase(350);
      drain();

      // zero rest lengths: every separated, weighted pair moves
      write_reg(REG_REST, '0);
      write_reg(REG_DIAG, '0);
      send_pair(make_pair(0, 1, 0, 0, 'h10000, 0, 0, 0, 'h10000), 1'b0, drive_moved, 1'b0);
      random_phase(350);
      drain();

      // largest rest lengths: only far pairs move
      write_reg(REG_REST, '1);
      write_reg(REG_DIAG, '1);
      random_phase(350);
      drain();

      // random rest lengths; unused indexes must leave them alone
      write_reg(REG_REST, REST_W'($urandom_range(0, 1 << 20)));
      write_reg(REG_DIAG, REST_W'($urandom));
      write_reg(REG_SPARE_LO, REST_W'($urandom));
      write_reg(REG_SPARE_HI, '1);
      random_phase(450);
      drain();

      // back to the reset values
      write_reg(REG_REST, REST_RESET);
      write_reg(REG_DIAG, DIAG_RESET);
      random_phase(400);
      drain();

      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d pairs over five rest length settings", pairs_sent);
      $display("checked %0d result words, %0d of them corrected", results_seen,
               corrected_seen);
      if (fail_count == 0 && moved_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### files.f
sv/dcp_pkg.sv
sv/dcp_sqrt_pipe.sv
sv/dcp_div_pipe.sv
sv/distance_constraint_projection_core.sv
dv/distance_constraint_projection_core_tb.sv
